// ===== rtl/lrc_pkg.sv =====
package lrc_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int OFFSET_BITS    = 26;
  localparam int COLOR_BITS     = 24;

  localparam int CLIP_W   = 12;
  localparam int WIN_W    = 13;
  localparam int BPP_W    = 3;
  localparam int STRIDE_W = 15;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE   = 3'd4;

  localparam logic [CLIP_W-1:0]   CLIP_LEFT_RST     = 12'd0;
  localparam logic [WIN_W-1:0]    WINDOW_WIDTH_RST  = 13'd1920;
  localparam logic [WIN_W-1:0]    WINDOW_HEIGHT_RST = 13'd1080;
  localparam logic [BPP_W-1:0]    BYTES_PER_PIX_RST = 3'd4;
  localparam logic [STRIDE_W-1:0] LINE_STRIDE_RST   = 15'd7680;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef struct packed {
    logic [CLIP_W-1:0]   clip_left;
    logic [WIN_W-1:0]    window_width;
    logic [WIN_W-1:0]    window_height;
    logic [BPP_W-1:0]    bytes_per_pixel;
    logic [STRIDE_W-1:0] line_stride;
  } lrc_cfg_t;

endpackage

// ===== rtl/lrc_ifs.sv =====
interface lrc_in_if #(
  parameter int COORD_BITS = lrc_pkg::COORD_BITS_DEF
) ();
  logic                              valid;
  logic                              ready;
  logic                              command;
  logic signed [COORD_BITS-1:0]      start_x;
  logic signed [COORD_BITS-1:0]      start_y;
  logic signed [COORD_BITS-1:0]      end_x;
  logic signed [COORD_BITS-1:0]      end_y;
  logic [lrc_pkg::COLOR_BITS-1:0]    line_color;

  modport source (output valid, command, start_x, start_y, end_x, end_y, line_color,
                  input ready);
  modport sink (input valid, command, start_x, start_y, end_x, end_y, line_color,
                output ready);
endinterface

interface lrc_out_if #(
  parameter int COORD_BITS = lrc_pkg::COORD_BITS_DEF
) ();
  logic                              valid;
  logic                              ready;
  logic signed [COORD_BITS-1:0]      pixel_x;
  logic signed [COORD_BITS-1:0]      pixel_y;
  logic [lrc_pkg::OFFSET_BITS-1:0]   byte_offset;
  logic                              write_enable;
  logic [lrc_pkg::COLOR_BITS-1:0]    pixel_color;
  logic                              line_done;

  modport source (output valid, pixel_x, pixel_y, byte_offset, write_enable, pixel_color,
                  line_done, input ready);
  modport sink (input valid, pixel_x, pixel_y, byte_offset, write_enable, pixel_color,
                line_done, output ready);
endinterface

// ===== rtl/lrc_core.sv =====
module lrc_core #(
  parameter int COORD_BITS = lrc_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  input  logic                             command,
  input  logic signed [COORD_BITS-1:0]     start_x,
  input  logic signed [COORD_BITS-1:0]     start_y,
  input  logic signed [COORD_BITS-1:0]     end_x,
  input  logic signed [COORD_BITS-1:0]     end_y,
  input  logic [lrc_pkg::COLOR_BITS-1:0]   line_color,
  input  lrc_pkg::lrc_cfg_t                cfg,
  output logic signed [COORD_BITS-1:0]     pixel_x,
  output logic signed [COORD_BITS-1:0]     pixel_y,
  output logic [lrc_pkg::OFFSET_BITS-1:0]  byte_offset,
  output logic                             write_enable,
  output logic [lrc_pkg::COLOR_BITS-1:0]   pixel_color,
  output logic                             line_done
);
  import lrc_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int CMP_W = (CB > WIN_W ? CB : WIN_W) + 1;
  localparam int PX_W  = CB + BPP_W;
  localparam int PY_W  = CB + STRIDE_W;
  localparam int SUM_W = (PY_W > OFFSET_BITS ? PY_W : OFFSET_BITS) + 1;

  logic signed [CB-1:0]   cursor_x_r, cursor_y_r, target_x_r, target_y_r;
  logic signed [CB-1:0]   cursor_x_nxt, cursor_y_nxt, target_x_nxt, target_y_nxt;
  logic [CB:0]            span_x_r, span_y_r, span_x_nxt, span_y_nxt;
  logic [1:0]             signs_r, signs_nxt;
  logic signed [CB+1:0]   err_r, err_nxt;
  logic [COLOR_BITS-1:0]  color_r, color_nxt;
  logic                   active_r, active_nxt;

  always_comb begin
    logic signed [CB:0]     dx, dy;
    logic signed [CB+2:0]   e2, neg_sy, sx3, sy3, err_wide;
    logic                   step_x, step_y, in_win;
    logic signed [CMP_W-1:0] xs, ys, clip_s, ww_s, wh_s;
    logic [CB-1:0]          xu, yu;
    logic [PX_W-1:0]        px;
    logic [PY_W-1:0]        py;
    logic [SUM_W-1:0]       off_sum;

    cursor_x_nxt = cursor_x_r;
    cursor_y_nxt = cursor_y_r;
    target_x_nxt = target_x_r;
    target_y_nxt = target_y_r;
    span_x_nxt   = span_x_r;
    span_y_nxt   = span_y_r;
    signs_nxt    = signs_r;
    err_nxt      = err_r;
    color_nxt    = color_r;
    active_nxt   = active_r;

    pixel_x      = '0;
    pixel_y      = '0;
    byte_offset  = '0;
    write_enable = 1'b0;
    pixel_color  = '0;
    line_done    = 1'b0;

    // load path
    dx = $signed({end_x[CB-1], end_x}) - $signed({start_x[CB-1], start_x});
    dy = $signed({end_y[CB-1], end_y}) - $signed({start_y[CB-1], start_y});

    // step path: Bresenham decision on the doubled error
    e2     = $signed({err_r, 1'b0});
    sx3    = $signed({2'b00, span_x_r});
    sy3    = $signed({2'b00, span_y_r});
    neg_sy = -sy3;
    step_x = e2 > neg_sy;
    step_y = e2 < sx3;
    err_wide = $signed({err_r[CB+1], err_r}) - (step_x ? sy3 : '0) + (step_y ? sx3 : '0);

    xs     = $signed({{(CMP_W-CB){cursor_x_r[CB-1]}}, cursor_x_r});
    ys     = $signed({{(CMP_W-CB){cursor_y_r[CB-1]}}, cursor_y_r});
    clip_s = $signed({{(CMP_W-CLIP_W){1'b0}}, cfg.clip_left});
    ww_s   = $signed({{(CMP_W-WIN_W){1'b0}}, cfg.window_width});
    wh_s   = $signed({{(CMP_W-WIN_W){1'b0}}, cfg.window_height});
    in_win = (xs >= clip_s) && (xs < ww_s) && !ys[CMP_W-1] && (ys < wh_s);

    // coordinates are non-negative whenever in_win holds
    xu      = cursor_x_r;
    yu      = cursor_y_r;
    px      = PX_W'(xu) * PX_W'(cfg.bytes_per_pixel);
    py      = PY_W'(yu) * PY_W'(cfg.line_stride);
    off_sum = SUM_W'(px) + SUM_W'(py);

    if (push) begin
      if (command == CMD_LOAD) begin
        span_x_nxt   = dx[CB] ? $unsigned(-dx) : $unsigned(dx);
        span_y_nxt   = dy[CB] ? $unsigned(-dy) : $unsigned(dy);
        signs_nxt[0] = !(start_x < end_x);
        signs_nxt[1] = !(start_y < end_y);
        err_nxt      = $signed({1'b0, span_x_nxt}) - $signed({1'b0, span_y_nxt});
        cursor_x_nxt = start_x;
        cursor_y_nxt = start_y;
        target_x_nxt = end_x;
        target_y_nxt = end_y;
        color_nxt    = line_color;
        active_nxt   = !((start_x == end_x) && (start_y == end_y));
        line_done    = !active_nxt;
      end else if (!active_r) begin
        line_done = 1'b1;
      end else begin
        pixel_x      = cursor_x_r;
        pixel_y      = cursor_y_r;
        pixel_color  = color_r;
        write_enable = in_win;
        byte_offset  = in_win ? off_sum[OFFSET_BITS-1:0] : '0;
        if (step_x) begin
          cursor_x_nxt = cursor_x_r + (signs_r[0] ? {CB{1'b1}} : CB'(1));
        end
        if (step_y) begin
          cursor_y_nxt = cursor_y_r + (signs_r[1] ? {CB{1'b1}} : CB'(1));
        end
        err_nxt = err_wide[CB+1:0];
        if ((cursor_x_nxt == target_x_r) && (cursor_y_nxt == target_y_r)) begin
          active_nxt = 1'b0;
          line_done  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r <= '0;
      cursor_y_r <= '0;
      target_x_r <= '0;
      target_y_r <= '0;
      span_x_r   <= '0;
      span_y_r   <= '0;
      signs_r    <= '0;
      err_r      <= '0;
      color_r    <= '0;
      active_r   <= 1'b0;
    end else begin
      cursor_x_r <= cursor_x_nxt;
      cursor_y_r <= cursor_y_nxt;
      target_x_r <= target_x_nxt;
      target_y_r <= target_y_nxt;
      span_x_r   <= span_x_nxt;
      span_y_r   <= span_y_nxt;
      signs_r    <= signs_nxt;
      err_r      <= err_nxt;
      color_r    <= color_nxt;
      active_r   <= active_nxt;
    end
  end

endmodule

// ===== rtl/lrc_skid.sv =====
module lrc_skid #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data
);

  logic              out_valid_r, skid_valid_r;
  logic [DATA_W-1:0] out_data_r, skid_data_r;
  logic              pop, push;

  assign in_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pop       = out_valid_r && out_ready;
  assign push      = in_valid && !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        // drain the skid entry; no transfer in can happen meanwhile
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end else if (push) begin
        out_data_r <= in_data;
      end else begin
        out_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r) begin
        out_data_r  <= in_data;
        out_valid_r <= 1'b1;
      end else begin
        skid_data_r  <= in_data;
        skid_valid_r <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/line_rasterizer_with_clip.sv =====
// Channel  Dir  Payload                                                  Transfer
// in_ch    in   command, start_x/y, end_x/y, line_color                  valid & ready
// out_ch   out  pixel_x/y, byte_offset, write_enable, pixel_color, done  valid & ready
// cfg      in   APB registers at 4*index, zero wait state                psel&penable&pwrite
//
// One item per clock while in_ch.ready is high: each command updates the line state in
// the cycle it is accepted and its result is registered in a two-entry output buffer.
// The pixel offset (one small and one 15-bit multiply) sits in that same cycle.
// in_ch.ready drops only while both buffer entries hold untaken results.
// rst_n is synchronous: the line goes idle, config registers take their defaults.
module line_rasterizer_with_clip #(
  parameter int COORD_BITS = lrc_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  lrc_in_if.sink                             in_ch,
  lrc_out_if.source                          out_ch,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [lrc_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [lrc_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [lrc_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready
);
  import lrc_pkg::*;

  localparam int RES_W = 2 * COORD_BITS + OFFSET_BITS + 1 + COLOR_BITS + 1;

  logic [CLIP_W-1:0]   clip_left_r;
  logic [WIN_W-1:0]    window_width_r, window_height_r;
  logic [BPP_W-1:0]    bytes_per_pixel_r;
  logic [STRIDE_W-1:0] line_stride_r;
  lrc_cfg_t            cfg;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic                cfg_wr;

  logic                          push, in_ready;
  logic signed [COORD_BITS-1:0]  res_x, res_y;
  logic [OFFSET_BITS-1:0]        res_off;
  logic                          res_we, res_done;
  logic [COLOR_BITS-1:0]         res_color;
  logic [RES_W-1:0]              res_data, out_data;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_left_r       <= CLIP_LEFT_RST;
      window_width_r    <= WINDOW_WIDTH_RST;
      window_height_r   <= WINDOW_HEIGHT_RST;
      bytes_per_pixel_r <= BYTES_PER_PIX_RST;
      line_stride_r     <= LINE_STRIDE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CLIP_LEFT:     clip_left_r       <= cfg_pwdata[CLIP_W-1:0];
        REG_WINDOW_WIDTH:  window_width_r    <= cfg_pwdata[WIN_W-1:0];
        REG_WINDOW_HEIGHT: window_height_r   <= cfg_pwdata[WIN_W-1:0];
        REG_BYTES_PER_PIX: bytes_per_pixel_r <= cfg_pwdata[BPP_W-1:0];
        REG_LINE_STRIDE:   line_stride_r     <= cfg_pwdata[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_CLIP_LEFT:     cfg_prdata = CFG_DATA_W'(clip_left_r);
      REG_WINDOW_WIDTH:  cfg_prdata = CFG_DATA_W'(window_width_r);
      REG_WINDOW_HEIGHT: cfg_prdata = CFG_DATA_W'(window_height_r);
      REG_BYTES_PER_PIX: cfg_prdata = CFG_DATA_W'(bytes_per_pixel_r);
      REG_LINE_STRIDE:   cfg_prdata = CFG_DATA_W'(line_stride_r);
      default:           cfg_prdata = '0;
    endcase
  end

  assign cfg.clip_left       = clip_left_r;
  assign cfg.window_width    = window_width_r;
  assign cfg.window_height   = window_height_r;
  assign cfg.bytes_per_pixel = bytes_per_pixel_r;
  assign cfg.line_stride     = line_stride_r;

  assign in_ch.ready = in_ready;
  assign push        = in_ch.valid && in_ready;

  lrc_core #(
    .COORD_BITS(COORD_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .command      (in_ch.command),
    .start_x      (in_ch.start_x),
    .start_y      (in_ch.start_y),
    .end_x        (in_ch.end_x),
    .end_y        (in_ch.end_y),
    .line_color   (in_ch.line_color),
    .cfg          (cfg),
    .pixel_x      (res_x),
    .pixel_y      (res_y),
    .byte_offset  (res_off),
    .write_enable (res_we),
    .pixel_color  (res_color),
    .line_done    (res_done)
  );

  assign res_data = {res_x, res_y, res_off, res_we, res_color, res_done};

  lrc_skid #(
    .DATA_W(RES_W)
  ) u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (push),
    .in_ready  (in_ready),
    .in_data   (res_data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign {out_ch.pixel_x, out_ch.pixel_y, out_ch.byte_offset, out_ch.write_enable,
          out_ch.pixel_color, out_ch.line_done} = out_data;

endmodule

// ===== verif/tb_line_rasterizer_with_clip.sv =====
module tb_line_rasterizer_with_clip;
  import lrc_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int LONG_HOLD   = 400;

  // address with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd5;

  typedef struct packed {
    logic                  command;
    logic [15:0]           start_x;
    logic [15:0]           start_y;
    logic [15:0]           end_x;
    logic [15:0]           end_y;
    logic [COLOR_BITS-1:0] color;
  } line_cmd_t;

  typedef struct packed {
    logic [15:0]            pixel_x;
    logic [15:0]            pixel_y;
    logic [OFFSET_BITS-1:0] byte_offset;
    logic                   write_enable;
    logic [COLOR_BITS-1:0]  pixel_color;
    logic                   line_done;
  } pixel_res_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  lrc_in_if  in_if ();
  lrc_out_if out_if ();

  line_rasterizer_with_clip dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register mirror, updated on each observed write transfer
  logic [CLIP_W-1:0]   win_left   = CLIP_LEFT_RST;
  logic [WIN_W-1:0]    win_width  = WINDOW_WIDTH_RST;
  logic [WIN_W-1:0]    win_height = WINDOW_HEIGHT_RST;
  logic [BPP_W-1:0]    pix_bytes  = BYTES_PER_PIX_RST;
  logic [STRIDE_W-1:0] row_stride = LINE_STRIDE_RST;

  // Line walker state
  logic signed [15:0]    cur_x = '0, cur_y = '0, tgt_x = '0, tgt_y = '0;
  longint                span_x = 0, span_y = 0, err_acc = 0;
  logic [1:0]            step_down = '0;
  logic [COLOR_BITS-1:0] held_color = '0;
  logic                  line_active = 1'b0;

  pixel_res_t expected_pixels[$];

  int  mismatches = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  pixels_written = 0;
  int  reg_writes = 0;
  int  stuck_cycles = 0;
  bit  idle_on = 1'b1;
  bit  hold_req = 1'b0;

  function automatic pixel_res_t rasterize(input line_cmd_t c);
    pixel_res_t r;
    longint ax, ay, bx, by, x, y, e2, off;
    longint lim_left, lim_w, lim_h, bpp, stride;
    logic [17:0] e18;
    r = '0;
    if (c.command == CMD_LOAD) begin
      ax = longint'($signed(c.start_x));
      ay = longint'($signed(c.start_y));
      bx = longint'($signed(c.end_x));
      by = longint'($signed(c.end_y));
      span_x = (bx > ax) ? bx - ax : ax - bx;
      span_y = (by > ay) ? by - ay : ay - by;
      step_down = {ay >= by, ax >= bx};
      e18 = 18'(span_x - span_y);
      err_acc = longint'($signed(e18));
      cur_x = c.start_x;
      cur_y = c.start_y;
      tgt_x = c.end_x;
      tgt_y = c.end_y;
      held_color = c.color;
      line_active = !(ax == bx && ay == by);
      r.line_done = !line_active;
    end else if (!line_active) begin
      r.line_done = 1'b1;
    end else begin
      x = longint'(cur_x);
      y = longint'(cur_y);
      lim_left = longint'(win_left);
      lim_w = longint'(win_width);
      lim_h = longint'(win_height);
      bpp = longint'(pix_bytes);
      stride = longint'(row_stride);
      r.pixel_x = cur_x;
      r.pixel_y = cur_y;
      if (x >= lim_left && x < lim_w && y >= 0 && y < lim_h) begin
        off = x * bpp + y * stride;
        r.byte_offset = off[OFFSET_BITS-1:0];
        r.write_enable = 1'b1;
      end
      r.pixel_color = held_color;
      e2 = 2 * err_acc;
      if (e2 > -span_y) begin
        err_acc = err_acc - span_y;
        cur_x = step_down[0] ? cur_x - 16'sd1 : cur_x + 16'sd1;
      end
      if (e2 < span_x) begin
        err_acc = err_acc + span_x;
        cur_y = step_down[1] ? cur_y - 16'sd1 : cur_y + 16'sd1;
      end
      e18 = 18'(err_acc);
      err_acc = longint'($signed(e18));
      if (cur_x == tgt_x && cur_y == tgt_y) begin
        line_active = 1'b0;
        r.line_done = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Observe every transfer: predict on input, check on output, mirror config writes
  always @(posedge clk) begin
    line_cmd_t  cmd;
    pixel_res_t want;
    bit         moved;
    moved = 1'b0;
    if (rst_n === 1'b1) begin
      if (in_if.valid && in_if.ready) begin
        cmd = {in_if.command, in_if.start_x, in_if.start_y, in_if.end_x, in_if.end_y,
               in_if.line_color};
        expected_pixels.push_back(rasterize(cmd));
        moved = 1'b1;
      end
      if (out_if.valid && out_if.ready) begin
        moved = 1'b1;
        results_seen++;
        if (out_if.write_enable === 1'b1) pixels_written++;
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 40)
            $display("%0t: result with none expected, actual x %0h y %0h done %0b",
                     $time, out_if.pixel_x, out_if.pixel_y, out_if.line_done);
        end else begin
          want = expected_pixels.pop_front();
          check_field("pixel_x", 32'(want.pixel_x), 32'($unsigned(out_if.pixel_x)));
          check_field("pixel_y", 32'(want.pixel_y), 32'($unsigned(out_if.pixel_y)));
          check_field("byte_offset", 32'(want.byte_offset), 32'(out_if.byte_offset));
          check_field("write_enable", 32'(want.write_enable), 32'(out_if.write_enable));
          check_field("pixel_color", 32'(want.pixel_color), 32'(out_if.pixel_color));
          check_field("line_done", 32'(want.line_done), 32'(out_if.line_done));
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        moved = 1'b1;
        reg_writes++;
        case (cfg_paddr[4:2])
          REG_CLIP_LEFT:     win_left   = cfg_pwdata[CLIP_W-1:0];
          REG_WINDOW_WIDTH:  win_width  = cfg_pwdata[WIN_W-1:0];
          REG_WINDOW_HEIGHT: win_height = cfg_pwdata[WIN_W-1:0];
          REG_BYTES_PER_PIX: pix_bytes  = cfg_pwdata[BPP_W-1:0];
          REG_LINE_STRIDE:   row_stride = cfg_pwdata[STRIDE_W-1:0];
          default: ;
        endcase
      end
      stuck_cycles = moved ? 0 : stuck_cycles + 1;
      if (stuck_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Result side: random holds, one long hold on request, none once idling is off
  initial begin
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  task automatic send_cmd(input logic cmd, input int sx, sy, ex, ey, input logic [23:0] color);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.command    <= cmd;
    in_if.start_x    <= sx[15:0];
    in_if.start_y    <= sy[15:0];
    in_if.end_x      <= ex[15:0];
    in_if.end_y      <= ey[15:0];
    in_if.line_color <= color;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic trace_line(input int sx, sy, ex, ey, input logic [23:0] color, input int steps);
    send_cmd(CMD_LOAD, sx, sy, ex, ey, color);
    repeat (steps) send_cmd(CMD_STEP, $urandom, $urandom, $urandom, $urandom, 24'($urandom));
  endtask

  // Drop valid and wait until every expected result is back
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val,
                           input int bits);
    logic [31:0] junk;
    junk = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= (junk << bits) | val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_window(input int left, width, height, bpp, stride);
    drain();
    write_reg(REG_CLIP_LEFT, left, CLIP_W);
    write_reg(REG_WINDOW_WIDTH, width, WIN_W);
    write_reg(REG_WINDOW_HEIGHT, height, WIN_W);
    write_reg(REG_BYTES_PER_PIX, bpp, BPP_W);
    write_reg(REG_LINE_STRIDE, stride, STRIDE_W);
  endtask

  // Short line starting near the window so pixels land on both sides of each edge
  task automatic random_line();
    int left, width, height, sx, sy, dx, dy, steps;
    left   = int'(win_left);
    width  = int'(win_width);
    height = int'(win_height);
    sx = left - 16 + $urandom_range(0, ((width > left) ? width - left : 1) + 32);
    sy = -16 + $urandom_range(0, height + 32);
    dx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 16);
    dy = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 16);
    steps = (dx > dy) ? dx : dy;
    if ($urandom_range(0, 1)) dx = -dx;
    if ($urandom_range(0, 1)) dy = -dy;
    case ($urandom_range(0, 9))
      0: steps = $urandom_range(0, steps);
      1: steps = steps + $urandom_range(1, 3);
      default: ;
    endcase
    trace_line(sx, sy, sx + dx, sy + dy, 24'($urandom), steps);
  endtask

  task automatic random_traffic(input int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 6) == 0)
        send_cmd(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom,
                 24'($urandom));
      else
        random_line();
    end
  endtask

  task automatic test_directed();
    send_cmd(CMD_STEP, 0, 0, 0, 0, 0);
    // degenerate line, then a step on the idle walker
    trace_line(5, 5, 5, 5, 24'h123456, 1);
    trace_line(0, 0, 3, 1, 24'hFFFFFF, 3);
    trace_line(-32768, -32768, 32767, 32767, 24'h000000, 2);
    trace_line(32767, 32767, -32768, -32768, 24'hA5A5A5, 1);
    // right edge of the default window
    trace_line(1921, 3, 1918, 3, 24'h00FF00, 3);
    // upward line that leaves through the top row
    trace_line(3, 1, 3, -2, 24'h0000FF, 3);
    trace_line(7, 2, 4, 9, 24'hFF0000, 2);
  endtask

  task automatic test_register_extremes();
    set_window(0, 0, 0, 0, 0);
    random_traffic(30);
    set_window(4095, 8191, 8191, 7, 32767);
    random_traffic(20);
    trace_line(8180, 8185, 8195, 8170, 24'h5A5A5A, 15);
    set_window(0, 4096, 4096, 1, 1);
    random_traffic(30);
    set_window(4095, 4096, 1, 4, 16384);
    random_traffic(30);
    set_window(10, 40, 30, 5, 9000);
    random_traffic(30);
    set_window(0, 30, 30, 6, 1234);
    drain();
    write_reg(REG_UNMAPPED, $urandom, 0);
    random_traffic(30);
  endtask

  task automatic random_window(input bit wide);
    int left;
    if (wide) begin
      set_window($urandom_range(0, 4095), $urandom_range(0, 8191), $urandom_range(0, 8191),
                 $urandom_range(0, 7), $urandom_range(0, 32767));
    end else begin
      left = $urandom_range(0, 64);
      set_window(left, left + $urandom_range(1, 128), $urandom_range(1, 128),
                 $urandom_range(1, 4), $urandom_range(1, 16384));
    end
  endtask

  task automatic test_random_phases();
    repeat (5) begin
      random_window($urandom_range(0, 3) == 0);
      random_traffic(150);
    end
  endtask

  task automatic test_output_backpressure();
    drain();
    hold_req = 1'b1;
    while (out_if.ready) @(posedge clk);
    // keep offering while results pile up
    trace_line(2, 2, 42, 20, 24'($urandom), 40);
    while (hold_req) @(posedge clk);
  endtask

  task automatic test_sender_pause();
    random_traffic(20);
    drain();
    random_traffic(20);
  endtask

  task automatic test_no_idle();
    drain();
    idle_on = 1'b0;
    random_window(1'b0);
    random_traffic(150);
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.command    <= CMD_LOAD;
    in_if.start_x    <= '0;
    in_if.start_y    <= '0;
    in_if.end_x      <= '0;
    in_if.end_y      <= '0;
    in_if.line_color <= '0;
    cfg_psel         <= 1'b0;
    cfg_penable      <= 1'b0;
    cfg_pwrite       <= 1'b0;
    cfg_paddr        <= '0;
    cfg_pwdata       <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_register_extremes();
    test_output_backpressure();
    test_sender_pause();
    test_random_phases();
    test_no_idle();

    drain();
    repeat (10) @(posedge clk);
    $display("Sent %0d commands over many window settings; %0d results checked, %0d written.",
             items_sent, results_seen, pixels_written);
    $display("Register writes: %0d; mismatches: %0d.", reg_writes, mismatches);
    if (mismatches == 0 && expected_pixels.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
